// ===== hw/rtl/gvrw_pkg.sv =====
// gvrw_pkg: shared types and constants for the voxel ray walk unit
// used by gvrw_div and grid_voxel_ray_walk_unit; no dependencies

package gvrw_pkg;

   // divider request and response between the walk control and the divider
   typedef struct packed {
      logic               start;
      logic signed [63:0] num;
      logic signed [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic signed [63:0] quo;
   } div_rsp_type;

   // operation codes of a request transaction
   localparam logic OP_TRACE = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CFG_CELLS_X = 2'd0;
   localparam logic [1:0] CFG_CELLS_Y = 2'd1;
   localparam logic [1:0] CFG_CELLS_Z = 2'd2;

   localparam logic [4:0]         CELLS_RESET = 5'd16;
   localparam logic signed [31:0] T_INF       = 32'sh7FFF_FFFF;
   localparam logic [5:0]         RESULT_CAP  = 6'd46;

   // axis of the nearest crossing from the three pairwise compares
   function automatic logic [1:0] axis_pick(input logic [2:0] bits);
      logic [1:0] ax;
      unique case (bits)
         3'd0:    ax = 2'd2;
         3'd1:    ax = 2'd1;
         3'd2:    ax = 2'd2;
         3'd3:    ax = 2'd1;
         3'd4:    ax = 2'd2;
         3'd5:    ax = 2'd2;
         3'd6:    ax = 2'd0;
         default: ax = 2'd0;
      endcase
      return ax;
   endfunction

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
      logic signed [31:0] r;
      if (x > 65'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -65'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/gvrw_div.sv =====
// gvrw_div: signed 64 by 32 bit divider, quotient truncated toward zero
// one quotient bit per cycle, restoring; uses gvrw_pkg types

module gvrw_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gvrw_pkg::div_req_type req,
   output gvrw_pkg::div_rsp_type rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dmag_ff, dmag_in;
   logic        neg_ff, neg_in;

   logic [32:0] rem_sh;
   logic        ge;

   assign rem_sh = {rem_ff, quo_ff[63]};
   assign ge     = rem_sh >= {1'b0, dmag_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd64;
         quo_in  = req.num[63] ? 64'(-req.num) : 64'(req.num);
         dmag_in = req.den[31] ? 32'(-req.den) : 32'(req.den);
         neg_in  = req.num[63] ^ req.den[31];
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift one dividend bit in, quotient bit collects at the bottom
         rem_in = ge ? 32'(rem_sh - {1'b0, dmag_ff}) : rem_sh[31:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

// ===== hw/rtl/grid_voxel_ray_walk_unit.sv =====
// grid_voxel_ray_walk_unit: 3d dda ray walk through a voxel occupancy grid
// depends on gvrw_pkg and gvrw_div

// channel | ports                        | direction | transaction moves
// req     | req_valid / req_ready        | in        | trace ray or occupancy word write
// rsp     | rsp_valid / rsp_ready        | out       | cell index, valid, last flag
// csr     | csr_valid / csr_ready        | in        | cells_x/y/z register write
//
// a word write is taken in the idle state; a trace runs an entry test (multiply,
// then check) on each axis, up to 3 x 2 divisions for box clipping, up to 2
// divisions per axis for crossing setup, then per visited cell an occupancy
// memory read, then a step, and last the final transaction; the shared divider
// sets the setup length, and rsp stalls lengthen a trace
// reset is synchronous and clears all occupancy valid bits at once
// a stalled rsp channel holds the walk at the next occupied cell

module grid_voxel_ray_walk_unit #(
   parameter int MAX_CELLS_PER_AXIS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic [30:0]        req_t_start,
   input  logic [30:0]        req_t_end,
   input  logic [5:0]         req_occ_address,
   input  logic [63:0]        req_occ_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_cell_index,
   output logic               rsp_cell_valid,
   output logic               rsp_last_result,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_data
);

   // width that holds a cell count up to the maximum
   localparam int NW = $clog2(MAX_CELLS_PER_AXIS + 1);
   localparam int IW = 3 * NW + 2;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_IN_MUL = 4'd1;
   localparam logic [3:0] ST_IN_CHK = 4'd2;
   localparam logic [3:0] ST_CL_AX  = 4'd3;
   localparam logic [3:0] ST_CL_WN  = 4'd4;
   localparam logic [3:0] ST_CL_DF  = 4'd5;
   localparam logic [3:0] ST_CL_WF  = 4'd6;
   localparam logic [3:0] ST_GR_MUL = 4'd7;
   localparam logic [3:0] ST_GR_CHK = 4'd8;
   localparam logic [3:0] ST_GR_DC  = 4'd9;
   localparam logic [3:0] ST_GR_WC  = 4'd10;
   localparam logic [3:0] ST_GR_DD  = 4'd11;
   localparam logic [3:0] ST_GR_WD  = 4'd12;
   localparam logic [3:0] ST_WK_RD  = 4'd13;
   localparam logic [3:0] ST_WK_EV  = 4'd14;
   localparam logic [3:0] ST_FIN    = 4'd15;

   // configuration registers
   logic [4:0] cfg_ff [3];

   // occupancy memory, valid bits stand in for the cleared reset state
   logic [63:0] occ_mem [64];
   logic [63:0] occ_vld_ff;
   logic [63:0] rd_word_ff;
   logic        rd_vld_ff;
   logic        mem_we, mem_re;
   logic [5:0]  mem_raddr;

   // control and walk state
   logic [3:0]            state_ff, state_in;
   logic [1:0]            ax_ff, ax_in;
   logic signed [31:0]    o_ff [3], o_in [3];
   logic signed [31:0]    d_ff [3], d_in [3];
   logic [30:0]           ts_ff, ts_in;
   logic [30:0]           te_ff, te_in;
   logic signed [63:0]    prod_ff, prod_in;
   logic                  inside_ff, inside_in;
   logic signed [63:0]    t0_ff, t0_in, t1_ff, t1_in, tn_ff, tn_in;
   logic [30:0]           rayt_ff, rayt_in;
   logic signed [63:0]    g_ff, g_in;
   logic [NW-1:0]         pos_ff [3], pos_in [3];
   logic signed [31:0]    crs_ff [3], crs_in [3];
   logic signed [31:0]    dlt_ff [3], dlt_in [3];
   logic [2:0]            sgn_ff, sgn_in;
   logic [2*NW-1:0]       nxy_ff, nxy_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [11:0]           pend_idx_ff, pend_idx_in;
   logic [5:0]            count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [11:0]           rsp_idx_ff, rsp_idx_in;
   logic                  rsp_cv_ff, rsp_cv_in;
   logic                  rsp_last_ff, rsp_last_in;

   gvrw_pkg::div_req_type div_req;
   gvrw_pkg::div_rsp_type div_rsp;

   // per axis cell count, out-of-range register values clamped
   logic [NW-1:0] n_arr [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (cfg_ff[i] == 5'd0) begin
            n_arr[i] = NW'(1);
         end else if (32'(cfg_ff[i]) > 32'(MAX_CELLS_PER_AXIS)) begin
            n_arr[i] = NW'(MAX_CELLS_PER_AXIS);
         end else begin
            n_arr[i] = NW'(cfg_ff[i]);
         end
      end
   end

   // linear cell index of the current position
   logic [IW-1:0] idx_full;
   logic [11:0]   idx;

   assign idx_full = IW'(pos_ff[0]) + IW'(pos_ff[1]) * IW'(n_arr[0])
                   + IW'(pos_ff[2]) * IW'(nxy_ff);
   assign idx      = idx_full[11:0];

   logic req_fire, rsp_fire, slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // selected-axis operands
   logic signed [31:0] o_sel, d_sel;
   logic signed [63:0] o_ext, n_q16, p_val, g_val, gq;
   logic [NW-1:0]      n_sel, start_cell;
   logic [30:0]        mul_t;
   logic signed [63:0] lo, hi, nt0, nt1;
   logic signed [64:0] qx, qabs;
   logic               up;

   // walk step decision
   logic [2:0]         cmp_bits;
   logic [1:0]         wax;
   logic               occ;

   always_comb begin
      o_sel = o_ff[ax_ff];
      d_sel = d_ff[ax_ff];
      n_sel = n_arr[ax_ff];
      o_ext = 64'(o_sel);
      n_q16 = $signed({{(48 - NW){1'b0}}, n_sel, 16'b0});
      mul_t = (state_ff == ST_IN_MUL) ? ts_ff : rayt_ff;
      p_val = o_ext + (prod_ff >>> 16);
      g_val = p_val;
      gq    = g_val >>> 16;
      if (g_val[63]) begin
         start_cell = '0;
      end else if (gq > $signed({{(64 - NW){1'b0}}, n_sel - NW'(1)})) begin
         start_cell = n_sel - NW'(1);
      end else begin
         start_cell = gq[NW-1:0];
      end
      up    = !d_sel[31];
      lo    = (tn_ff < div_rsp.quo) ? tn_ff : div_rsp.quo;
      hi    = (tn_ff < div_rsp.quo) ? div_rsp.quo : tn_ff;
      nt0   = (lo > t0_ff) ? lo : t0_ff;
      nt1   = (hi < t1_ff) ? hi : t1_ff;
      qx    = 65'(div_rsp.quo);
      qabs  = qx[64] ? -qx : qx;

      cmp_bits = {crs_ff[0] < crs_ff[1], crs_ff[0] < crs_ff[2], crs_ff[1] < crs_ff[2]};
      wax      = gvrw_pkg::axis_pick(cmp_bits);
      occ      = rd_vld_ff && rd_word_ff[idx[5:0]];
   end

   assign prod_in = d_sel * $signed({1'b0, mul_t});

   // divider operands by setup step
   always_comb begin
      div_req.start = 1'b0;
      div_req.den   = d_sel;
      div_req.num   = '0;
      unique case (state_ff)
         ST_CL_AX: begin
            div_req.num = (64'sd0 - o_ext) <<< 16;
         end
         ST_CL_DF: begin
            div_req.num = (n_q16 - o_ext) <<< 16;
         end
         ST_GR_DC: begin
            div_req.num = (($signed({{(48 - NW){1'b0}}, pos_ff[ax_ff], 16'b0})
                          + (up ? 64'sh1_0000 : 64'sd0)) - g_ff) <<< 16;
         end
         ST_GR_DD: begin
            div_req.num = 64'sh1_0000_0000;
         end
         default: begin
            div_req.num = '0;
         end
      endcase
      div_req.start = (state_ff == ST_CL_AX && d_sel != 32'sd0)
                   || state_ff == ST_CL_DF || state_ff == ST_GR_DC
                   || state_ff == ST_GR_DD;
   end

   gvrw_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // main sequencer
   always_comb begin
      state_in      = state_ff;
      ax_in         = ax_ff;
      ts_in         = ts_ff;
      te_in         = te_ff;
      inside_in     = inside_ff;
      t0_in         = t0_ff;
      t1_in         = t1_ff;
      tn_in         = tn_ff;
      rayt_in       = rayt_ff;
      g_in          = g_ff;
      sgn_in        = sgn_ff;
      nxy_in        = nxy_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_cv_in     = rsp_cv_ff;
      rsp_last_in   = rsp_last_ff;
      mem_re        = 1'b0;
      for (int i = 0; i < 3; i++) begin
         o_in[i]   = o_ff[i];
         d_in[i]   = d_ff[i];
         pos_in[i] = pos_ff[i];
         crs_in[i] = crs_ff[i];
         dlt_in[i] = dlt_ff[i];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_operation == gvrw_pkg::OP_TRACE) begin
               o_in[0]       = req_origin_x;
               o_in[1]       = req_origin_y;
               o_in[2]       = req_origin_z;
               d_in[0]       = req_dir_x;
               d_in[1]       = req_dir_y;
               d_in[2]       = req_dir_z;
               ts_in         = req_t_start;
               te_in         = req_t_end;
               nxy_in        = (2*NW)'(n_arr[0]) * (2*NW)'(n_arr[1]);
               ax_in         = 2'd0;
               inside_in     = 1'b1;
               count_in      = '0;
               pend_valid_in = 1'b0;
               sgn_in        = '0;
               state_in      = ST_IN_MUL;
            end
         end
         ST_IN_MUL: begin
            state_in = ST_IN_CHK;
         end
         ST_IN_CHK: begin
            // closed box test of the point at t_start
            if (p_val < 64'sd0 || p_val > n_q16) begin
               inside_in = 1'b0;
            end
            if (ax_ff == 2'd2) begin
               ax_in = 2'd0;
               if (inside_ff && !(p_val < 64'sd0 || p_val > n_q16)) begin
                  rayt_in  = ts_ff;
                  state_in = ST_GR_MUL;
               end else begin
                  t0_in    = 64'(ts_ff);
                  t1_in    = 64'(te_ff);
                  state_in = ST_CL_AX;
               end
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_IN_MUL;
            end
         end
         ST_CL_AX: begin
            if (d_sel == 32'sd0) begin
               // flat slab: origin must lie within it
               if (o_ext < 64'sd0 || o_ext > n_q16) begin
                  state_in = ST_FIN;
               end else if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  rayt_in  = t0_ff[30:0];
                  state_in = ST_GR_MUL;
               end else begin
                  ax_in = ax_ff + 2'd1;
               end
            end else begin
               state_in = ST_CL_WN;
            end
         end
         ST_CL_WN: begin
            if (div_rsp.done) begin
               tn_in    = div_rsp.quo;
               state_in = ST_CL_DF;
            end
         end
         ST_CL_DF: begin
            state_in = ST_CL_WF;
         end
         ST_CL_WF: begin
            if (div_rsp.done) begin
               t0_in = nt0;
               t1_in = nt1;
               if (nt0 > nt1) begin
                  state_in = ST_FIN;
               end else if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  rayt_in  = nt0[30:0];
                  state_in = ST_GR_MUL;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = ST_CL_AX;
               end
            end
         end
         ST_GR_MUL: begin
            state_in = ST_GR_CHK;
         end
         ST_GR_CHK: begin
            g_in          = g_val;
            pos_in[ax_ff] = start_cell;
            if (d_sel == 32'sd0) begin
               crs_in[ax_ff] = gvrw_pkg::T_INF;
               dlt_in[ax_ff] = gvrw_pkg::T_INF;
               if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  state_in = ST_WK_RD;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = ST_GR_MUL;
               end
            end else begin
               sgn_in[ax_ff] = d_sel[31];
               state_in      = ST_GR_DC;
            end
         end
         ST_GR_DC: begin
            state_in = ST_GR_WC;
         end
         ST_GR_WC: begin
            if (div_rsp.done) begin
               crs_in[ax_ff] = gvrw_pkg::sat32(65'(rayt_ff) + qx);
               state_in      = ST_GR_DD;
            end
         end
         ST_GR_DD: begin
            state_in = ST_GR_WD;
         end
         ST_GR_WD: begin
            if (div_rsp.done) begin
               dlt_in[ax_ff] = gvrw_pkg::sat32(qabs);
               if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  state_in = ST_WK_RD;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = ST_GR_MUL;
               end
            end
         end
         ST_WK_RD: begin
            mem_re   = 1'b1;
            state_in = ST_WK_EV;
         end
         ST_WK_EV: begin
            // an occupied cell pushes the held one out; wait if rsp is full
            if (!(occ && count_ff < gvrw_pkg::RESULT_CAP && pend_valid_ff && !slot_free)) begin
               if (occ && count_ff < gvrw_pkg::RESULT_CAP) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_idx_in   = pend_idx_ff;
                     rsp_cv_in    = 1'b1;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = idx;
                  count_in      = count_ff + 6'd1;
               end
               if ($signed({1'b0, te_ff}) < crs_ff[wax] || crs_ff[wax] == gvrw_pkg::T_INF) begin
                  state_in = ST_FIN;
               end else if (sgn_ff[wax] ? (pos_ff[wax] == '0)
                                        : (pos_ff[wax] == n_arr[wax] - NW'(1))) begin
                  state_in = ST_FIN;
               end else begin
                  pos_in[wax] = sgn_ff[wax] ? pos_ff[wax] - NW'(1) : pos_ff[wax] + NW'(1);
                  crs_in[wax] = gvrw_pkg::sat32(65'(crs_ff[wax]) + 65'(dlt_ff[wax]));
                  state_in    = ST_WK_RD;
               end
            end
         end
         ST_FIN: begin
            // final transaction: last held cell, or the empty result
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = pend_valid_ff ? pend_idx_ff : 12'd0;
               rsp_cv_in    = pend_valid_ff;
               rsp_last_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mem_we    = req_fire && req_operation == gvrw_pkg::OP_WRITE;
   assign mem_raddr = idx[11:6];

   // occupancy memory, one write or one read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         occ_mem[req_occ_address] <= req_occ_word;
      end
      if (mem_re) begin
         rd_word_ff <= occ_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (mem_we) begin
            occ_vld_ff[req_occ_address] <= 1'b1;
         end
         if (mem_re) begin
            rd_vld_ff <= occ_vld_ff[mem_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            cfg_ff[i] <= gvrw_pkg::CELLS_RESET;
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               gvrw_pkg::CFG_CELLS_X: cfg_ff[0] <= csr_data;
               gvrw_pkg::CFG_CELLS_Y: cfg_ff[1] <= csr_data;
               gvrw_pkg::CFG_CELLS_Z: cfg_ff[2] <= csr_data;
               default: begin
               end
            endcase
         end
      end
      ax_ff       <= ax_in;
      ts_ff       <= ts_in;
      te_ff       <= te_in;
      prod_ff     <= prod_in;
      inside_ff   <= inside_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      tn_ff       <= tn_in;
      rayt_ff     <= rayt_in;
      g_ff        <= g_in;
      sgn_ff      <= sgn_in;
      nxy_ff      <= nxy_in;
      pend_idx_ff <= pend_idx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_cv_ff   <= rsp_cv_in;
      rsp_last_ff <= rsp_last_in;
      for (int i = 0; i < 3; i++) begin
         o_ff[i]   <= o_in[i];
         d_ff[i]   <= d_in[i];
         pos_ff[i] <= pos_in[i];
         crs_ff[i] <= crs_in[i];
         dlt_ff[i] <= dlt_in[i];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_index  = rsp_idx_ff;
   assign rsp_cell_valid  = rsp_cv_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule
